// ----- hw/rtl/atpb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atpb_pkg
// Shared types and constants for the ASCII triple point binner.
// ----------------------------------------------------------------------------
package atpb_pkg;

  // Character code of digit '1'; digits are one-based.
  localparam logic [7:0] DIGIT_BASE   = 8'd49;
  // Reset value of the end marker, '>'.
  localparam logic [7:0] MARKER_RESET = 8'd62;

  // Position of the next character inside a triple.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // Result fields known at the end of the first stage.
  typedef struct packed {
    logic       frame_done;
    logic       frame_dropped;
    logic       point_valid;
    logic [6:0] layer_count;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ascii_triple_point_binner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_triple_point_binner
// Parses framed characters as x,y,z digit triples into per-layer point lists
// held in a two-bank point memory; published points are read back on request.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   tuser: kind; tdata: char_code, read_layer,
//                                   read_slot
// m_*      out  m_tvalid/m_tready   tuser: frame_done; tdata: frame_dropped,
//                                   point_valid, point_x, point_y, layer_count
// cfg_*    in   cfg_we              cfg_wdata: end_marker
//
// One request per cycle while s_tready is high; each result passes through
// the point memory's registered read port and then the output register.
// Counts live in flip-flops so a character updates them in its accept cycle.
// Reset clears all control state and counts; the point memory
// is not cleared. A stalled output holds the one request in flight and
// deasserts s_tready only while both the stage and the output are full.
// ----------------------------------------------------------------------------
module ascii_triple_point_binner #(
  parameter int LAYERS           = 8,
  parameter int ROWS             = 8,
  parameter int COLS             = 8,
  parameter int POINTS_PER_LAYER = 64,
  parameter int FRAME_CHARS      = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], read_layer[10:8], read_slot[16:11]
  input  wire logic        s_tuser,   // kind[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // frame_dropped[0], point_valid[1], point_x[4:2],
                                      // point_y[7:5], layer_count[14:8]
  output logic             m_tuser    // frame_done[0]
);

  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int SW    = (POINTS_PER_LAYER > 1) ? $clog2(POINTS_PER_LAYER) : 1;
  localparam int CW    = $clog2(POINTS_PER_LAYER + 1);
  localparam int XW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int YW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int DEPTH = 2 * LAYERS * POINTS_PER_LAYER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FLW   = $clog2(FRAME_CHARS);
  localparam logic [FLW-1:0] FL_LIMIT = FLW'(FRAME_CHARS - 2);

  // Control and frame state
  logic [7:0]             end_marker;
  atpb_pkg::phase_t       char_phase;
  logic [7:0]             held_first;
  logic [7:0]             held_second;
  logic [FLW-1:0]         frame_length;
  logic                   working_bank;
  logic                   overflow_seen;
  logic [CW-1:0]          counts [2][LAYERS];

  // Point memory, {x, y} per entry
  logic [XW+YW-1:0]       point_mem [DEPTH];
  logic [XW+YW-1:0]       rd_data;

  // Pipeline
  logic                   s1_valid;
  atpb_pkg::res_t         s1_res;
  logic                   out_free;
  logic                   s_fire;

  // Request decode
  logic [7:0]             ch;
  logic [2:0]             rl;
  logic [5:0]             rs;
  logic                   is_marker;
  logic                   too_long;
  logic [8:0]             dx, dy, dz;
  logic                   triple_ok;
  logic [LW-1:0]          z_idx;
  logic [CW-1:0]          wcnt;
  logic                   wfull;
  logic                   take;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic                   rl_ok;
  logic [LW-1:0]          rl_idx;
  logic [CW-1:0]          pcnt;
  logic                   pt_ok;
  logic                   mem_re;
  logic [AW-1:0]          rd_addr;
  atpb_pkg::res_t         res_next;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_free;
  assign s_fire   = s_tvalid && s_tready;

  assign ch = s_tdata[7:0];
  assign rl = s_tdata[10:8];
  assign rs = s_tdata[16:11];

  assign is_marker = (ch == end_marker);
  assign too_long  = (frame_length >= FL_LIMIT);

  assign dx = {1'b0, held_first}  - {1'b0, atpb_pkg::DIGIT_BASE};
  assign dy = {1'b0, held_second} - {1'b0, atpb_pkg::DIGIT_BASE};
  assign dz = {1'b0, ch}          - {1'b0, atpb_pkg::DIGIT_BASE};

  assign triple_ok = (held_first  >= atpb_pkg::DIGIT_BASE) && (32'(dx) < ROWS) &&
                     (held_second >= atpb_pkg::DIGIT_BASE) && (32'(dy) < COLS) &&
                     (ch          >= atpb_pkg::DIGIT_BASE) && (32'(dz) < LAYERS);

  assign z_idx = LW'(dz);
  assign wcnt  = counts[working_bank][z_idx];
  assign wfull = (32'(wcnt) >= POINTS_PER_LAYER);

  assign take    = s_fire && !s_tuser && !is_marker && !too_long &&
                   (char_phase == atpb_pkg::PH_THIRD);
  assign mem_we  = take && triple_ok && !wfull;
  assign wr_addr = AW'((32'(working_bank) * LAYERS + 32'(z_idx)) * POINTS_PER_LAYER
                       + 32'(wcnt));

  // Reads see the published bank, the one not being filled.
  assign rl_ok   = (32'(rl) < LAYERS);
  assign rl_idx  = LW'(rl);
  assign pcnt    = counts[!working_bank][rl_idx];
  assign pt_ok   = rl_ok && (32'(rs) < 32'(pcnt));
  assign mem_re  = s_fire && s_tuser && pt_ok;
  assign rd_addr = AW'((32'(!working_bank) * LAYERS + 32'(rl_idx)) * POINTS_PER_LAYER
                       + 32'(SW'(rs)));

  always_comb begin
    res_next = '0;
    if (!s_tuser) begin
      if (is_marker) begin
        res_next.frame_done    = 1'b1;
        res_next.frame_dropped = overflow_seen;
      end
    end else if (rl_ok) begin
      res_next.layer_count = 7'(pcnt);
      res_next.point_valid = pt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      point_mem[wr_addr] <= {XW'(dx), YW'(dy)};
    end
    if (mem_re) begin
      rd_data <= point_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker    <= atpb_pkg::MARKER_RESET;
      char_phase    <= atpb_pkg::PH_FIRST;
      held_first    <= '0;
      held_second   <= '0;
      frame_length  <= '0;
      working_bank  <= 1'b0;
      overflow_seen <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int l = 0; l < LAYERS; l++) begin
          counts[b][l] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        end_marker <= cfg_wdata;
      end
      if (s_fire && !s_tuser) begin
        if (is_marker) begin
          // Publish: swap banks and start the new working bank empty.
          working_bank  <= !working_bank;
          overflow_seen <= 1'b0;
          char_phase    <= atpb_pkg::PH_FIRST;
          frame_length  <= '0;
          for (int l = 0; l < LAYERS; l++) begin
            counts[!working_bank][l] <= '0;
          end
        end else if (too_long) begin
          // Restart the parse, drop the character.
          overflow_seen <= 1'b0;
          char_phase    <= atpb_pkg::PH_FIRST;
          frame_length  <= '0;
          for (int l = 0; l < LAYERS; l++) begin
            counts[working_bank][l] <= '0;
          end
        end else begin
          frame_length <= frame_length + 1'b1;
          case (char_phase)
            atpb_pkg::PH_FIRST: begin
              held_first <= ch;
              char_phase <= atpb_pkg::PH_SECOND;
            end
            atpb_pkg::PH_SECOND: begin
              held_second <= ch;
              char_phase  <= atpb_pkg::PH_THIRD;
            end
            default: begin
              char_phase <= atpb_pkg::PH_FIRST;
              if (triple_ok) begin
                if (wfull) begin
                  overflow_seen <= 1'b1;
                end else begin
                  counts[working_bank][z_idx] <= wcnt + 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  // Stage 1 and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_fire;
      end
      if (out_free) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_res <= res_next;
    end
    if (out_free && s1_valid) begin
      m_tuser       <= s1_res.frame_done;
      m_tdata[0]    <= s1_res.frame_dropped;
      m_tdata[1]    <= s1_res.point_valid;
      m_tdata[4:2]  <= s1_res.point_valid ? 3'(rd_data[XW+YW-1:YW]) : 3'd0;
      m_tdata[7:5]  <= s1_res.point_valid ? 3'(rd_data[YW-1:0]) : 3'd0;
      m_tdata[14:8] <= s1_res.layer_count;
      m_tdata[15]   <= 1'b0;
    end
  end

  // Assertions
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[1] && (m_tdata[14:8] == 7'd0))
    else $error("frame result carries point fields");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> (m_tdata[7:2] == 6'd0))
    else $error("invalid point with nonzero coordinates");

  assert property (@(posedge clk) disable iff (rst)
    frame_length <= FL_LIMIT)
    else $error("frame length past restart limit");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_res))
    else $error("stalled stage lost its request");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re)
    else $error("point memory write and read in one cycle");

endmodule
`default_nettype wire

// ----- sim/tb_ascii_triple_point_binner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ascii_triple_point_binner
// Self-checking bench: streams character frames and point reads into the
// binner, predicts every result from a cycle-free model of the parser and the
// two point banks, and compares each result field by field in order. Runs
// under random gaps on both sides, one long output stall and several markers.
// ----------------------------------------------------------------------------
module tb_ascii_triple_point_binner;

  localparam bit KIND_CHAR = 1'b0;
  localparam bit KIND_READ = 1'b1;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic       done;
    logic       dropped;
    logic       valid;
    logic [2:0] x;
    logic [2:0] y;
    logic [6:0] count;
  } point_result_t;

  class point_scoreboard;
    localparam int LAYER_N     = 8;
    localparam int ROW_N       = 8;
    localparam int COL_N       = 8;
    localparam int LIST_DEPTH  = 64;
    localparam int FRAME_LIMIT = 256;

    logic [7:0]        marker;
    atpb_pkg::phase_t  phase;
    logic [7:0]        first_ch;
    logic [7:0]        second_ch;
    int unsigned       frame_len;
    int unsigned       work_cnt[LAYER_N];
    int unsigned       pub_cnt[LAYER_N];
    logic [2:0]        x_mem[2*LAYER_N*LIST_DEPTH];
    logic [2:0]        y_mem[2*LAYER_N*LIST_DEPTH];
    bit                bank;
    bit                overflow;
    point_result_t     expected_q[$];
    int unsigned       errors;

    function new();
      marker = atpb_pkg::MARKER_RESET;
      first_ch = '0;
      second_ch = '0;
      bank = 1'b0;
      errors = 0;
      foreach (pub_cnt[i]) pub_cnt[i] = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      foreach (work_cnt[i]) work_cnt[i] = 0;
      overflow = 1'b0;
      phase = atpb_pkg::PH_FIRST;
      frame_len = 0;
    endfunction

    function void bin_triple(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int x;
      int y;
      int z;
      int idx;
      if (a < atpb_pkg::DIGIT_BASE || b < atpb_pkg::DIGIT_BASE ||
          c < atpb_pkg::DIGIT_BASE) return;
      x = int'(a) - int'(atpb_pkg::DIGIT_BASE);
      y = int'(b) - int'(atpb_pkg::DIGIT_BASE);
      z = int'(c) - int'(atpb_pkg::DIGIT_BASE);
      if (x >= ROW_N || y >= COL_N || z >= LAYER_N) return;
      // full list: drop the point, keep the count
      if (work_cnt[z] >= LIST_DEPTH) begin
        overflow = 1'b1;
        return;
      end
      idx = (int'(bank) * LAYER_N + z) * LIST_DEPTH + int'(work_cnt[z]);
      x_mem[idx] = x[2:0];
      y_mem[idx] = y[2:0];
      work_cnt[z]++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(bit kind, logic [7:0] ch, logic [2:0] layer,
                               logic [5:0] slot);
      point_result_t o;
      int idx;
      o = '0;
      if (kind == KIND_CHAR) begin
        if (ch == marker) begin
          foreach (pub_cnt[i]) pub_cnt[i] = work_cnt[i];
          o.done = 1'b1;
          o.dropped = overflow;
          bank = !bank;
          restart_frame();
        end else if (frame_len + 1 >= FRAME_LIMIT - 1) begin
          restart_frame();
        end else begin
          frame_len++;
          case (phase)
            atpb_pkg::PH_FIRST: begin
              first_ch = ch;
              phase = atpb_pkg::PH_SECOND;
            end
            atpb_pkg::PH_SECOND: begin
              second_ch = ch;
              phase = atpb_pkg::PH_THIRD;
            end
            default: begin
              bin_triple(first_ch, second_ch, ch);
              phase = atpb_pkg::PH_FIRST;
            end
          endcase
        end
      end else if (int'(layer) < LAYER_N) begin
        o.count = pub_cnt[layer][6:0];
        if (slot < pub_cnt[layer]) begin
          // reads see the bank that was published last
          idx = ((bank ? 0 : 1) * LAYER_N + int'(layer)) * LIST_DEPTH + int'(slot);
          o.valid = 1'b1;
          o.x = x_mem[idx];
          o.y = y_mem[idx];
        end
      end
      expected_q.push_back(o);
    endfunction

    function void compare(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic user, logic [15:0] data);
      point_result_t o;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: tuser %0d tdata %h", user, data);
        errors++;
        return;
      end
      o = expected_q.pop_front();
      compare("frame_done", o.done, user);
      compare("frame_dropped", o.dropped, data[0]);
      compare("point_valid", o.valid, data[1]);
      compare("point_x", o.x, data[4:2]);
      compare("point_y", o.y, data[7:5]);
      compare("layer_count", o.count, data[14:8]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // char_code[7:0], read_layer[10:8], read_slot[16:11]
  logic        s_tuser = 1'b0; // kind[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // frame_dropped[0], point_valid[1], point_x[4:2],
                               // point_y[7:5], layer_count[14:8]
  logic        m_tuser;        // frame_done[0]

  point_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned src_calm_left = 0;
  int unsigned sink_calm_left = 0;
  bit long_stall_done = 1'b0;

  ascii_triple_point_binner uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tuser, m_tdata);
        results_seen++;
      end
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[16:11]);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // output side: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned r;
    wait (!rst);
    forever begin
      if (!long_stall_done && results_seen >= 150) begin
        long_stall_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (sink_calm_left > 0) begin
        sink_calm_left--;
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          sink_calm_left = $urandom_range(20, 80);
          m_tready <= 1'b1;
          @(posedge clk);
        end else if (r < 70) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (pick_gap()) @(posedge clk);
        end
      end
    end
  end

  task automatic send_req(bit kind, logic [7:0] ch, logic [2:0] layer, logic [5:0] slot);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_calm_left > 0) begin
      src_calm_left--;
    end else if (r < 3) begin
      src_calm_left = $urandom_range(20, 80);
    end else if (r >= 70) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, slot, layer, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] ch);
    send_req(KIND_CHAR, ch, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
  endtask

  task automatic send_read(logic [2:0] layer, logic [5:0] slot);
    send_req(KIND_READ, 8'($urandom_range(0, 255)), layer, slot);
  endtask

  task automatic send_triple(int x, int y, int z);
    send_char(atpb_pkg::DIGIT_BASE + 8'(x));
    send_char(atpb_pkg::DIGIT_BASE + 8'(y));
    send_char(atpb_pkg::DIGIT_BASE + 8'(z));
  endtask

  // aim half the reads at the published list, up to one past its end
  task automatic send_reads(int n);
    logic [2:0] layer;
    int unsigned cnt;
    for (int i = 0; i < n; i++) begin
      layer = 3'($urandom_range(0, 7));
      cnt = sb.pub_cnt[layer];
      if ($urandom_range(0, 1) == 0 || cnt == 0)
        send_read(layer, 6'($urandom_range(0, 63)));
      else
        send_read(layer, 6'((cnt > 63) ? $urandom_range(0, 63) : $urandom_range(0, cnt)));
    end
  endtask

  task automatic frame_normal();
    int n;
    int r;
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_reads(1);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_triple($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
      end else if (r < 93) begin
        repeat (3) send_char(8'($urandom_range(48, 57)));
      end else begin
        repeat (3) send_char(8'($urandom_range(0, 255)));
      end
    end
    // trailing partial triple
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2))
        send_char(atpb_pkg::DIGIT_BASE + 8'($urandom_range(0, 7)));
    send_char(sb.marker);
    send_reads($urandom_range(1, 6));
  endtask

  // push one layer past its list depth
  task automatic frame_saturate();
    int z;
    z = $urandom_range(0, 7);
    repeat ($urandom_range(66, 72))
      send_triple($urandom_range(0, 7), $urandom_range(0, 7), z);
    send_char(sb.marker);
    send_read(3'(z), 6'd63);
    send_read(3'(z), 6'($urandom_range(0, 63)));
  endtask

  // overrun the frame length so the parse restarts, then finish a short frame
  task automatic frame_long();
    logic [7:0] ch;
    repeat ($urandom_range(255, 262)) begin
      ch = atpb_pkg::DIGIT_BASE + 8'($urandom_range(0, 7));
      if (ch == sb.marker) ch = ch + 8'd1;
      send_char(ch);
    end
    send_triple($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
    send_triple($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
    send_char(sb.marker);
    send_reads(4);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 12))
      send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
  endtask

  task automatic run_random(int unsigned upto);
    int r;
    while (items_sent < upto) begin
      r = $urandom_range(0, 99);
      if (r < 60) frame_normal();
      else if (r < 70) send_char(sb.marker);
      else if (r < 76) frame_saturate();
      else if (r < 79) frame_long();
      else noise_burst();
    end
  endtask

  // drain everything in flight, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_marker(logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.marker = value;
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty lists, corner digits, out-of-range and partial triples
    send_read(3'd0, 6'd0);
    send_triple(0, 0, 0);
    send_triple(7, 7, 7);
    send_char(8'd48);
    send_char(atpb_pkg::DIGIT_BASE);
    send_char(atpb_pkg::DIGIT_BASE);
    send_triple(8, 8, 0);
    send_char(atpb_pkg::DIGIT_BASE + 8'd1);
    send_char(atpb_pkg::DIGIT_BASE + 8'd2);
    send_char(sb.marker);
    send_read(3'd0, 6'd0);
    send_read(3'd7, 6'd0);
    send_read(3'd7, 6'd1);
    send_read(3'd3, 6'd63);
    send_char(sb.marker);
    send_read(3'd0, 6'd0);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'h01);
    send_char(sb.marker);

    frame_saturate();
    frame_long();
    run_random(250);

    write_marker(8'h00);
    run_random(450);
    write_marker(8'hFF);
    run_random(650);
    write_marker(8'($urandom_range(0, 255)));
    run_random(800);
    write_marker(atpb_pkg::MARKER_RESET);
    run_random(900);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
